// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define CHECK_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define CHECK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define CHECK_IMPLY(lbl, clk, rstn, ante, cons)
`define CHECK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/snfcs_pkg.sv =====
package snfcs_pkg;

	localparam int PAGE_BYTES_DEF  = 256;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int ADDR_W          = 24;
	localparam int COUNT_W         = 16;
	localparam int BYTE_W          = 8;
	localparam int STEP_W          = 3;
	localparam int STATUS_BUSY_BIT = 0;

	// flash opcodes
	localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_RDSR  = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_PP    = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_SE    = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_BE    = 8'hD8;
	localparam logic [BYTE_W-1:0] CMD_PDOWN = 8'hB9;
	localparam logic [BYTE_W-1:0] CMD_WAKE  = 8'hAB;
	localparam logic [BYTE_W-1:0] DUMMY     = 8'h00;

	// result kinds
	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_REFUSE = 2'd3;

	typedef enum logic [2:0] {
		ACT_READ   = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_WDATA  = 3'd2,
		ACT_SECTOR = 3'd3,
		ACT_BLOCK  = 3'd4,
		ACT_PDOWN  = 3'd5,
		ACT_WAKE   = 3'd6,
		ACT_REPLY  = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_READ  = 3'd1,
		PH_WPRE  = 3'd2,
		PH_WDATA = 3'd3,
		PH_WPOST = 3'd4,
		PH_EPRE  = 3'd5,
		PH_EPOST = 3'd6
	} phase_t;

	// frame bundles the back end expands
	typedef enum logic [3:0] {
		J_REFUSE      = 4'd0,
		J_POWER       = 4'd1,
		J_READ_START  = 4'd2,
		J_ENABLE_POLL = 4'd3,
		J_POLL        = 4'd4,
		J_PROGRAM     = 4'd5,
		J_ERASE       = 4'd6,
		J_READ_BYTE   = 4'd7,
		J_DATA        = 4'd8,
		J_DONE        = 4'd9
	} job_op_t;

	typedef struct packed {
		job_op_t           op;
		logic [BYTE_W-1:0] data;  // opcode, write byte or read byte
		logic [ADDR_W-1:0] addr;
		logic              flag;  // hold select on the read dummy or write data frame
		logic              more;  // read: another dummy frame; data: page ends
	} job_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [BYTE_W-1:0] tx;
		logic              hold;
		logic              want;
		logic [BYTE_W-1:0] rd;
		logic              last;
	} res_t;

endpackage

// ===== rtl/core/snfcs_front.sv =====
module snfcs_front #(
	parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      action,
	input  logic [snfcs_pkg::ADDR_W-1:0]    flash_address,
	input  logic [snfcs_pkg::COUNT_W-1:0]   byte_count,
	input  logic [snfcs_pkg::BYTE_W-1:0]    write_byte,
	input  logic [snfcs_pkg::BYTE_W-1:0]    reply_byte,
	input  logic                            q_full,
	output logic                            job_valid,
	output snfcs_pkg::job_t                 job
);
	import snfcs_pkg::*;

	// page size is a power of two
	localparam int PAGE_W = $clog2(PAGE_BYTES);
	localparam int ROOM_W = PAGE_W + 1;

	phase_t              phase_q, phase_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [COUNT_W-1:0]  left_q, left_d;
	logic [ROOM_W-1:0]   room_q, room_d;
	logic                blk_q, blk_d;

	action_t             act;
	logic                accept;
	logic                busy;
	logic [ADDR_W-1:0]   room_addr;
	logic [COUNT_W-1:0]  room_left;
	logic [ROOM_W-1:0]   room_gap;
	logic [ROOM_W-1:0]   room_new;
	logic [COUNT_W-1:0]  left_dec;
	logic [ADDR_W-1:0]   addr_inc;
	logic [ROOM_W-1:0]   room_dec;

	assign act      = action_t'(action);
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign busy     = reply_byte[STATUS_BUSY_BIT];
	assign left_dec = left_q - COUNT_W'(1);
	assign addr_inc = addr_q + ADDR_W'(1);
	assign room_dec = (room_q != '0) ? room_q - ROOM_W'(1) : '0;

	// room left in the page: write start uses the request, later pages the counters
	assign room_addr = (phase_q == PH_IDLE) ? flash_address : addr_q;
	assign room_left = (phase_q == PH_IDLE) ? byte_count : left_q;
	assign room_gap  = ROOM_W'(PAGE_BYTES) - {1'b0, room_addr[PAGE_W-1:0]};
	assign room_new  = (room_left < COUNT_W'(room_gap)) ? room_left[ROOM_W-1:0] : room_gap;

	always_comb begin
		phase_d  = phase_q;
		addr_d   = addr_q;
		left_d   = left_q;
		room_d   = room_q;
		blk_d    = blk_q;
		job.op   = J_REFUSE;
		job.data = '0;
		job.addr = addr_q;
		job.flag = 1'b0;
		job.more = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if ((act == ACT_READ || act == ACT_WRITE) && byte_count == '0) begin
					job.op = J_REFUSE;
				end else if (act == ACT_READ) begin
					addr_d   = flash_address;
					left_d   = byte_count;
					job.op   = J_READ_START;
					job.addr = flash_address;
					job.flag = (byte_count > COUNT_W'(1));
					phase_d  = PH_READ;
				end else if (act == ACT_WRITE) begin
					addr_d  = flash_address;
					left_d  = byte_count;
					room_d  = room_new;
					job.op  = J_ENABLE_POLL;
					phase_d = PH_WPRE;
				end else if (act == ACT_SECTOR || act == ACT_BLOCK) begin
					addr_d  = flash_address;
					blk_d   = (act == ACT_BLOCK);
					job.op  = J_ENABLE_POLL;
					phase_d = PH_EPRE;
				end else if (act == ACT_PDOWN || act == ACT_WAKE) begin
					job.op   = J_POWER;
					job.data = (act == ACT_PDOWN) ? CMD_PDOWN : CMD_WAKE;
				end
			end
			PH_READ: begin
				if (act == ACT_REPLY) begin
					job.op   = J_READ_BYTE;
					job.data = reply_byte;
					job.more = (left_dec != '0);
					job.flag = (left_dec > COUNT_W'(1));
					left_d   = left_dec;
					addr_d   = addr_inc;
					if (left_dec == '0) begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_WPRE: begin
				if (act == ACT_REPLY) begin
					if (busy) begin
						job.op = J_POLL;
					end else begin
						job.op  = J_PROGRAM;
						phase_d = PH_WDATA;
					end
				end
			end
			PH_WDATA: begin
				if (act == ACT_WDATA) begin
					job.op   = J_DATA;
					job.data = write_byte;
					job.flag = (room_q > ROOM_W'(1));
					job.more = (room_dec == '0);
					addr_d   = addr_inc;
					left_d   = left_dec;
					room_d   = room_dec;
					if (room_dec == '0) begin
						phase_d = PH_WPOST;
					end
				end
			end
			PH_WPOST, PH_EPOST: begin
				if (act == ACT_REPLY) begin
					if (busy) begin
						job.op = J_POLL;
					end else if (phase_q == PH_WPOST && left_q != '0) begin
						room_d  = room_new;
						job.op  = J_ENABLE_POLL;
						phase_d = PH_WPRE;
					end else begin
						job.op  = J_DONE;
						blk_d   = 1'b0;
						phase_d = PH_IDLE;
					end
				end
			end
			PH_EPRE: begin
				if (act == ACT_REPLY) begin
					if (busy) begin
						job.op = J_POLL;
					end else begin
						job.op   = J_ERASE;
						job.data = blk_q ? CMD_BE : CMD_SE;
						phase_d  = PH_EPOST;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign job_valid = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			left_q  <= '0;
			room_q  <= '0;
			blk_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			left_q  <= left_d;
			room_q  <= room_d;
			blk_q   <= blk_d;
		end
	end

endmodule

// ===== rtl/core/snfcs_queue.sv =====
module snfcs_queue #(
	parameter int DEPTH = snfcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  snfcs_pkg::job_t  push_job,
	output logic             full,
	input  logic             pop,
	output snfcs_pkg::job_t  head,
	output logic             empty
);
	import snfcs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t              slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/snfcs_back.sv =====
module snfcs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  snfcs_pkg::job_t               head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [snfcs_pkg::BYTE_W-1:0]  tx_byte,
	output logic                          hold_select,
	output logic                          want_reply,
	output logic [snfcs_pkg::BYTE_W-1:0]  read_byte,
	output logic                          last
);
	import snfcs_pkg::*;

	function automatic res_t mk_frame(logic [BYTE_W-1:0] tx, logic hold, logic want,
		logic lst);
		res_t r;
		r.kind = KIND_FRAME;
		r.tx   = tx;
		r.hold = hold;
		r.want = want;
		r.rd   = '0;
		r.last = lst;
		return r;
	endfunction

	function automatic res_t mk_status(logic [1:0] k, logic [BYTE_W-1:0] rd, logic lst);
		res_t r;
		r.kind = k;
		r.tx   = '0;
		r.hold = 1'b0;
		r.want = 1'b0;
		r.rd   = rd;
		r.last = lst;
		return r;
	endfunction

	// one result of a job at a given step
	function automatic res_t result_at(job_t j, logic [STEP_W-1:0] s);
		res_t r;
		r = mk_status(KIND_REFUSE, '0, 1'b1);
		case (j.op)
			J_REFUSE: r = mk_status(KIND_REFUSE, '0, 1'b1);
			J_DONE:   r = mk_status(KIND_DONE, '0, 1'b1);
			J_POWER:
				r = (s == '0) ? mk_frame(j.data, 1'b0, 1'b0, 1'b0)
				              : mk_status(KIND_DONE, '0, 1'b1);
			J_POLL:
				r = (s == '0) ? mk_frame(CMD_RDSR, 1'b1, 1'b0, 1'b0)
				              : mk_frame(DUMMY, 1'b0, 1'b1, 1'b1);
			J_ENABLE_POLL: begin
				case (s)
					3'd0:    r = mk_frame(CMD_WREN, 1'b0, 1'b0, 1'b0);
					3'd1:    r = mk_frame(CMD_RDSR, 1'b1, 1'b0, 1'b0);
					default: r = mk_frame(DUMMY, 1'b0, 1'b1, 1'b1);
				endcase
			end
			J_READ_START, J_PROGRAM, J_ERASE: begin
				case (s)
					3'd0: begin
						case (j.op)
							J_READ_START: r = mk_frame(CMD_READ, 1'b1, 1'b0, 1'b0);
							J_PROGRAM:    r = mk_frame(CMD_PP, 1'b1, 1'b0, 1'b0);
							default:      r = mk_frame(j.data, 1'b1, 1'b0, 1'b0);
						endcase
					end
					3'd1:    r = mk_frame(j.addr[23:16], 1'b1, 1'b0, 1'b0);
					3'd2:    r = mk_frame(j.addr[15:8], 1'b1, 1'b0, 1'b0);
					3'd3:    r = mk_frame(j.addr[7:0], j.op != J_ERASE, 1'b0,
					                      j.op == J_PROGRAM);
					3'd4: begin
						if (j.op == J_READ_START) begin
							r = mk_frame(DUMMY, j.flag, 1'b1, 1'b1);
						end else begin
							r = mk_frame(CMD_RDSR, 1'b1, 1'b0, 1'b0);
						end
					end
					default: r = mk_frame(DUMMY, 1'b0, 1'b1, 1'b1);
				endcase
			end
			J_READ_BYTE: begin
				if (s == '0) begin
					r = mk_status(KIND_DATA, j.data, 1'b0);
				end else if (j.more) begin
					r = mk_frame(DUMMY, j.flag, 1'b1, 1'b1);
				end else begin
					r = mk_status(KIND_DONE, '0, 1'b1);
				end
			end
			J_DATA: begin
				case (s)
					3'd0:    r = mk_frame(j.data, j.flag, 1'b0, !j.more);
					3'd1:    r = mk_frame(CMD_RDSR, 1'b1, 1'b0, 1'b0);
					default: r = mk_frame(DUMMY, 1'b0, 1'b1, 1'b1);
				endcase
			end
			default: r = mk_status(KIND_REFUSE, '0, 1'b1);
		endcase
		return r;
	endfunction

	job_t               job_q;
	logic               active_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	res_t               out_q;
	res_t               res;
	logic               advance;
	logic               finishing;

	assign res       = result_at(job_q, step_q);
	assign advance   = active_q && (!out_valid_q || !out_stall);
	assign finishing = advance && res.last;
	assign pop       = !q_empty && (!active_q || finishing);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (finishing) begin
				active_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign tx_byte     = out_q.tx;
	assign hold_select = out_q.hold;
	assign want_reply  = out_q.want;
	assign read_byte   = out_q.rd;
	assign last        = out_q.last;

endmodule

// ===== rtl/core/spi_nor_flash_command_sequencer.sv =====
// Path: an item passes the job queue, the back-end job register and the output register in turn.
// Throughput: one item per cycle enters while the job queue has room; the back end
// sends one result per cycle unless the output stalls, and an item yields 1 to 6 results.
// Reset: arst_n low clears the phase, counters, job queue and output valid at once.
// Address, count and page-room counters restart at zero, and the phase at idle.
`include "assert_macros.svh"

module spi_nor_flash_command_sequencer #(
	parameter int PAGE_BYTES  = snfcs_pkg::PAGE_BYTES_DEF,   // power of two, 16 to 4096
	parameter int QUEUE_DEPTH = snfcs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [2:0]   action,
	input  logic [23:0]  flash_address,
	input  logic [15:0]  byte_count,
	input  logic [7:0]   write_byte,
	input  logic [7:0]   reply_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   kind,
	output logic [7:0]   tx_byte,
	output logic         hold_select,
	output logic         want_reply,
	output logic [7:0]   read_byte,
	output logic         last
);
	import snfcs_pkg::*;

	// Front end: track the flash phase and turn each transfer into one job.
	// Queue: hold jobs so either side can stall on its own.
	// Back end: expand a job into its frames and status results, one per cycle unless the output stalls.
	logic  job_valid;
	job_t  job;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	job_t  q_head;
	logic  frame_bits_clear;

	snfcs_front #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.flash_address(flash_address),
		.byte_count   (byte_count),
		.write_byte   (write_byte),
		.reply_byte   (reply_byte),
		.q_full       (q_full),
		.job_valid    (job_valid),
		.job          (job)
	);

	snfcs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.push_job(job),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	snfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.hold_select(hold_select),
		.want_reply (want_reply),
		.read_byte  (read_byte),
		.last       (last)
	);

	assign frame_bits_clear = !hold_select && !want_reply && (tx_byte == 8'h00);

	// a refusal is always the only result of its item
	`CHECK_IMPLY(a_refuse_last, clk, arst_n, out_valid && kind == KIND_REFUSE, last)
	// frame-only fields stay clear on status results
	`CHECK_IMPLY(a_status_clean, clk, arst_n, out_valid && kind != KIND_FRAME, frame_bits_clear)
	// read data only rides on data results
	`CHECK_IMPLY(a_rd_only_data, clk, arst_n, out_valid && kind != KIND_DATA, read_byte == 8'h00)
	// an accepted transfer lands in the job queue
	`CHECK_NEXT(a_job_queued, clk, arst_n, in_valid && !in_stall, !q_empty)

endmodule
